// File: src/tpos_pkg.sv
`timescale 1ns / 1ps

package tpos_pkg;

    localparam int TONE_SLOTS = 8;
    localparam int SINE_CODE  = 0;
    localparam int SLOT_W     = (TONE_SLOTS > 1) ? $clog2(TONE_SLOTS) : 1;

    localparam logic [15:0] FREQ_MIN  = 16'd100;
    localparam logic [15:0] FREQ_MAX  = 16'd8000;
    localparam logic [15:0] DUR_MIN   = 16'd5;
    localparam logic [15:0] DUR_MAX   = 16'd100;
    localparam logic [15:0] LEVEL_MAX = 16'd100;

    typedef enum logic [2:0] {
        MODE_DEFINE = 3'd0,
        MODE_PLAY   = 3'd1,
        MODE_SCHED  = 3'd2,
        MODE_TICK   = 3'd3,
        MODE_RESET  = 3'd4
    } mode_t;

    typedef struct packed {
        logic [12:0] freq;
        logic [6:0]  dur;
        logic [6:0]  level;
    } tone_t;

    localparam tone_t DEFAULT_CLICK = '{freq: 13'd1000, dur: 7'd30, level: 7'd100};
    localparam tone_t TONE_ZERO     = '{freq: 13'd0, dur: 7'd0, level: 7'd0};

    typedef struct packed {
        logic [2:0]         mode;
        logic [7:0]         slot;
        logic [7:0]         wave;
        logic [15:0]        freq_req;
        logic [15:0]        dur_req;
        logic signed [15:0] level_req;
        logic [31:0]        request_time;
        logic [31:0]        now_ms;
    } item_t;

    typedef struct packed {
        logic  status;
        logic  play;
        tone_t tone;
    } result_t;

    // scheduler -> palette control
    typedef struct packed {
        logic              wr_en;
        logic              clear;
        logic [SLOT_W-1:0] idx;
        tone_t             wr_tone;
    } pal_ctl_t;

    // palette -> scheduler read data
    typedef struct packed {
        logic  valid;
        tone_t tone;
    } pal_rd_t;

    function automatic tone_t clamp_tone(logic [15:0] f, logic [15:0] d,
                                         logic signed [15:0] l);
        logic [15:0] fc;
        logic [15:0] dc;
        logic [15:0] lc;
        tone_t       t;
        fc = (f < FREQ_MIN) ? FREQ_MIN : ((f > FREQ_MAX) ? FREQ_MAX : f);
        dc = (d < DUR_MIN) ? DUR_MIN : ((d > DUR_MAX) ? DUR_MAX : d);
        if (l[15])
            lc = 16'd0;
        else if (16'(l) > LEVEL_MAX)
            lc = LEVEL_MAX;
        else
            lc = 16'(l);
        t.freq  = fc[12:0];
        t.dur   = dc[6:0];
        t.level = lc[6:0];
        return t;
    endfunction

endpackage

// File: src/tpos_cmd_if.sv
`timescale 1ns / 1ps

interface tpos_cmd_if;
    logic               valid;
    logic               ready;
    logic [2:0]         mode;
    logic [7:0]         slot;
    logic [7:0]         wave;
    logic [15:0]        freq_req;
    logic [15:0]        dur_req;
    logic signed [15:0] level_req;
    logic [31:0]        request_time;
    logic [31:0]        now_ms;

    modport source (
        output valid, mode, slot, wave, freq_req, dur_req, level_req,
               request_time, now_ms,
        input  ready
    );
    modport sink (
        input  valid, mode, slot, wave, freq_req, dur_req, level_req,
               request_time, now_ms,
        output ready
    );
endinterface

// File: src/tpos_rsp_if.sv
`timescale 1ns / 1ps

interface tpos_rsp_if;
    logic        valid;
    logic        ready;
    logic        status;
    logic        play;
    logic [12:0] tone_freq;
    logic [6:0]  tone_dur;
    logic [6:0]  tone_level;

    modport source (
        output valid, status, play, tone_freq, tone_dur, tone_level,
        input  ready
    );
    modport sink (
        input  valid, status, play, tone_freq, tone_dur, tone_level,
        output ready
    );
endinterface

// File: src/tone_palette_one_shot_scheduler_unit.sv
`timescale 1ns / 1ps

// Channel  Dir  Fields
// cmd      in   mode, slot, wave, freq_req, dur_req, level_req, request_time, now_ms
// rsp      out  status, play, tone_freq, tone_dur, tone_level
//
// One request per cycle unless rsp stalls; a taken request is held in the request register
// and its response becomes valid once it moves into the response register.
// Request register feeds palette read and scheduler compares, which land in the
// response register; state updates when the request moves into it.
// rsp stall holds the response register and a full request register; cmd.ready drops
// only while both are full and rsp.ready is low.
// Async reset: slot 0 holds the default click, nothing pending, times zero.

module tone_palette_one_shot_scheduler_unit (
    input logic       clk,
    input logic       rst_n,
    tpos_cmd_if.sink   cmd,
    tpos_rsp_if.source rsp
);
    import tpos_pkg::*;

    item_t    item_reg;
    logic     item_valid_reg;
    logic     item_valid_next;
    result_t  res_reg;
    logic     res_valid_reg;
    logic     res_valid_next;

    logic     advance;
    logic     step;
    logic     cmd_take;
    pal_ctl_t pal_ctl;
    pal_rd_t  pal_rd;
    result_t  res;

    assign advance   = !res_valid_reg || rsp.ready;
    assign step      = item_valid_reg && advance;
    assign cmd.ready = !item_valid_reg || advance;
    assign cmd_take  = cmd.valid && cmd.ready;

    assign item_valid_next = cmd_take ? 1'b1 : (step ? 1'b0 : item_valid_reg);
    assign res_valid_next  = advance ? item_valid_reg : res_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            item_valid_reg <= item_valid_next;
            res_valid_reg  <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_take)
        begin
            item_reg.mode         <= cmd.mode;
            item_reg.slot         <= cmd.slot;
            item_reg.wave         <= cmd.wave;
            item_reg.freq_req     <= cmd.freq_req;
            item_reg.dur_req      <= cmd.dur_req;
            item_reg.level_req    <= cmd.level_req;
            item_reg.request_time <= cmd.request_time;
            item_reg.now_ms       <= cmd.now_ms;
        end
        if (step)
            res_reg <= res;
    end

    tpos_palette u_palette (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (pal_ctl),
        .rd    (pal_rd)
    );

    tpos_sched u_sched (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (step),
        .item  (item_reg),
        .rd    (pal_rd),
        .ctl   (pal_ctl),
        .res   (res)
    );

    assign rsp.valid      = res_valid_reg;
    assign rsp.status     = res_reg.status;
    assign rsp.play       = res_reg.play;
    assign rsp.tone_freq  = res_reg.tone.freq;
    assign rsp.tone_dur   = res_reg.tone.dur;
    assign rsp.tone_level = res_reg.tone.level;

`ifndef ASSERT_OFF
    a_silent_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && !rsp.play |->
            rsp.tone_freq == 13'd0 && rsp.tone_dur == 7'd0 && rsp.tone_level == 7'd0)
        else $error("silent response carries tone data");

    a_err_silent: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.status |-> !rsp.play)
        else $error("error response sounds a tone");

    a_tone_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.play |->
            rsp.tone_freq >= 13'd100 && rsp.tone_freq <= 13'd8000 &&
            rsp.tone_dur >= 7'd5 && rsp.tone_dur <= 7'd100 && rsp.tone_level <= 7'd100)
        else $error("sounded tone out of clamp range");

    a_stall_only: assert property (@(posedge clk) disable iff (!rst_n)
        !cmd.ready |-> item_valid_reg && res_valid_reg && !rsp.ready)
        else $error("request side stalled without a full pipe");
`endif

endmodule

// File: src/tpos_palette.sv
`timescale 1ns / 1ps

module tpos_palette (
    input  logic               clk,
    input  logic               rst_n,
    input  tpos_pkg::pal_ctl_t ctl,
    output tpos_pkg::pal_rd_t  rd
);
    import tpos_pkg::*;

    tone_t                 table_reg [TONE_SLOTS];
    logic [TONE_SLOTS-1:0] valid_reg;
    logic [TONE_SLOTS-1:0] valid_next;
    // slot 0 reads as the default click until it is redefined
    logic                  dflt_reg;
    logic                  dflt_next;

    always_comb
    begin
        valid_next = valid_reg;
        dflt_next  = dflt_reg;
        if (ctl.clear)
        begin
            valid_next = TONE_SLOTS'(1);
            dflt_next  = 1'b1;
        end
        else if (ctl.wr_en)
        begin
            valid_next[ctl.idx] = 1'b1;
            if (ctl.idx == '0)
                dflt_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= TONE_SLOTS'(1);
            dflt_reg  <= 1'b1;
        end
        else
        begin
            valid_reg <= valid_next;
            dflt_reg  <= dflt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en && !ctl.clear)
            table_reg[ctl.idx] <= ctl.wr_tone;
    end

    always_comb
    begin
        rd.valid = valid_reg[ctl.idx];
        if (ctl.idx == '0 && dflt_reg)
            rd.tone = DEFAULT_CLICK;
        else
            rd.tone = table_reg[ctl.idx];
    end

endmodule

// File: src/tpos_sched.sv
`timescale 1ns / 1ps

module tpos_sched (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               step,
    input  tpos_pkg::item_t    item,
    input  tpos_pkg::pal_rd_t  rd,
    output tpos_pkg::pal_ctl_t ctl,
    output tpos_pkg::result_t  res
);
    import tpos_pkg::*;

    logic [31:0] pend_time_reg;
    logic [31:0] pend_time_next;
    tone_t       pend_tone_reg;
    tone_t       pend_tone_next;
    logic [31:0] last_fired_reg;
    logic [31:0] last_fired_next;

    logic        slot_ok;
    logic        fetch_ok;
    logic        displace_hit;
    logic [31:0] now_inc;

    assign slot_ok  = {1'b0, item.slot} < 9'(TONE_SLOTS);
    assign fetch_ok = slot_ok && rd.valid;
    assign now_inc  = item.now_ms + 32'd1;

    // replaced tone is overdue and not yet fired
    assign displace_hit = (pend_time_reg != 32'd0) && (pend_time_reg != item.request_time)
                       && (pend_time_reg <= item.now_ms) && (pend_time_reg > last_fired_reg);

    always_comb
    begin
        pend_time_next  = pend_time_reg;
        pend_tone_next  = pend_tone_reg;
        last_fired_next = last_fired_reg;
        ctl.idx         = item.slot[SLOT_W-1:0];
        ctl.wr_en       = 1'b0;
        ctl.clear       = 1'b0;
        ctl.wr_tone     = clamp_tone(item.freq_req, item.dur_req, item.level_req);
        res.status      = 1'b0;
        res.play        = 1'b0;
        res.tone        = TONE_ZERO;

        case (item.mode)
            MODE_DEFINE:
            begin
                if (!slot_ok || item.wave != 8'(SINE_CODE))
                    res.status = 1'b1;
                else
                    ctl.wr_en = step;
            end
            MODE_PLAY:
            begin
                if (!fetch_ok)
                    res.status = 1'b1;
                else
                begin
                    res.play = 1'b1;
                    res.tone = rd.tone;
                end
            end
            MODE_SCHED:
            begin
                if (item.request_time == 32'd0)
                    pend_time_next = 32'd0;
                else if (!fetch_ok)
                    res.status = 1'b1;
                else if (item.request_time > last_fired_reg)
                begin
                    if (displace_hit)
                    begin
                        last_fired_next = pend_time_reg;
                        res.play        = 1'b1;
                        res.tone        = pend_tone_reg;
                    end
                    pend_time_next = item.request_time;
                    pend_tone_next = rd.tone;
                end
            end
            MODE_TICK:
            begin
                if (pend_time_reg != 32'd0 && pend_time_reg <= now_inc)
                begin
                    res.play        = 1'b1;
                    res.tone        = pend_tone_reg;
                    last_fired_next = pend_time_reg;
                    pend_time_next  = 32'd0;
                end
            end
            MODE_RESET:
            begin
                ctl.clear       = step;
                pend_time_next  = 32'd0;
                pend_tone_next  = TONE_ZERO;
                last_fired_next = 32'd0;
            end
            default:
            begin
                res.status = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_time_reg  <= '0;
            pend_tone_reg  <= TONE_ZERO;
            last_fired_reg <= '0;
        end
        else if (step)
        begin
            pend_time_reg  <= pend_time_next;
            pend_tone_reg  <= pend_tone_next;
            last_fired_reg <= last_fired_next;
        end
    end

endmodule
